@@ design/stok_pkg.sv @@
// Shared types, token codes, scan-mode codes and the keyword table of the
// source tokenizer. No dependencies.
`timescale 1ns / 1ps

package stok_pkg;

  // Longest identifier run is IDENT_MAX-1 characters; lexeme length saturates
  localparam logic [7:0] IDENT_MAX  = 8'd9;
  localparam logic [7:0] STRING_MAX = 8'd255;

  localparam logic [30:0] INT_SAT  = 31'h7FFF_FFFF;
  localparam logic [23:0] LINE_SAT = 24'hFF_FFFF;

  // Scan modes
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_IDENT = 4'd1;
  localparam logic [3:0] M_NUM   = 4'd2;
  localparam logic [3:0] M_STR   = 4'd3;
  localparam logic [3:0] M_EQ    = 4'd4;
  localparam logic [3:0] M_LT    = 4'd5;
  localparam logic [3:0] M_GT    = 4'd6;
  localparam logic [3:0] M_PLUS  = 4'd7;
  localparam logic [3:0] M_MINUS = 4'd8;

  // Token kinds
  localparam logic [4:0] K_EOF      = 5'd0;
  localparam logic [4:0] K_IDENT    = 5'd1;
  localparam logic [4:0] K_INT      = 5'd2;
  localparam logic [4:0] K_STR      = 5'd3;
  localparam logic [4:0] K_KEYBASE  = 5'd4;
  localparam logic [4:0] K_ASSIGN   = 5'd11;
  localparam logic [4:0] K_EQEQ     = 5'd12;
  localparam logic [4:0] K_SEMI     = 5'd13;
  localparam logic [4:0] K_LPAREN   = 5'd14;
  localparam logic [4:0] K_RPAREN   = 5'd15;
  localparam logic [4:0] K_LT       = 5'd16;
  localparam logic [4:0] K_LE       = 5'd17;
  localparam logic [4:0] K_GT       = 5'd18;
  localparam logic [4:0] K_GE       = 5'd19;
  localparam logic [4:0] K_LBRACE   = 5'd20;
  localparam logic [4:0] K_RBRACE   = 5'd21;
  localparam logic [4:0] K_COMMA    = 5'd22;
  localparam logic [4:0] K_STAR     = 5'd23;
  localparam logic [4:0] K_SLASH    = 5'd24;
  localparam logic [4:0] K_PLUS     = 5'd25;
  localparam logic [4:0] K_PLUSPLUS = 5'd26;
  localparam logic [4:0] K_MINUS    = 5'd27;
  localparam logic [4:0] K_MINMIN   = 5'd28;
  localparam logic [4:0] K_ERROR    = 5'd29;

  // Characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // Keywords packed first character in the low byte, in token-kind order
  localparam int KW_COUNT = 7;
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h6C65_7661_6972_6176,   // variavel
    64'h0000_6F61_636E_7566,   // funcao
    64'h0000_0000_6172_6170,   // para
    64'h0000_0000_0000_6573,   // se
    64'h0000_006F_616E_6573,   // senao
    64'h7269_6D69_7270_6D69,   // imprimir
    64'h0065_6E72_6F74_6572    // retorne
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd8, 8'd6, 8'd4, 8'd2, 8'd5, 8'd8, 8'd7
  };

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [30:0] int_value;
    logic [63:0] text;
    logic [7:0]  text_length;
    logic [23:0] line_number;
    logic [7:0]  bad_char;
    logic        overflow;
    logic        last;
  } tok_t;

  // Up to two tokens come out of one byte
  typedef struct packed {
    logic r0_valid;
    logic r1_valid;
    tok_t r0;
    tok_t r1;
  } scan_res_t;

  function automatic logic [4:0] ident_kind(logic [63:0] text, logic [7:0] len);
    logic [4:0] kind;
    kind = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (text == KW_TEXT[i] && len == KW_LEN[i]) begin
        kind = K_KEYBASE + 5'(i);
      end
    end
    return kind;
  endfunction

endpackage

@@ design/source_tokenizer.sv @@
// Top level of the source tokenizer: scanner core plus a four-entry token
// queue feeding the output stream. Depends on stok_pkg and stok_scan.
//
//  channel  | dir | tdata                               | tuser        | tlast
//  ---------+-----+-------------------------------------+--------------+-------------
//  s_axis   | in  | char_code                           | end_of_input | -
//  m_axis   | out | kind,int,text,length,line,bad,ovf   | -            | last of byte
//
// One byte is taken per cycle; its tokens enter the queue in the same edge.
// A byte that ends one token and makes another yields two beats; s_axis stalls
// only while the queue has under two free entries. The queue lets input
// continue while m_axis is stalled.
// Reset clears the scan mode, the lexeme, the line count and the queue.
`timescale 1ns / 1ps

module source_tokenizer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tuser,   // [0] end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // [4:0] token_kind, [35:5] int_value,
                                       // [99:36] text, [107:100] text_length,
                                       // [131:108] line_number, [139:132] bad_char,
                                       // [140] overflow, [143:141] zero
  output logic         m_axis_tlast
);

  stok_pkg::scan_res_t res;
  stok_pkg::tok_t      q_mem [4];
  stok_pkg::tok_t      head;

  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic [1:0] push_n;
  logic       s_accept;
  logic       m_accept;

  assign s_axis_tready = count_q <= 3'd2;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;

  stok_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (s_accept),
    .char_code_i    (s_axis_tdata),
    .end_of_input_i (s_axis_tuser),
    .res_o          (res)
  );

  always_comb begin
    push_n = 2'd0;
    if (s_accept) begin
      push_n = {1'b0, res.r0_valid} + {1'b0, res.r1_valid};
    end
    wr_ptr_d = wr_ptr_q + push_n;
    rd_ptr_d = rd_ptr_q + {1'b0, m_accept};
    count_d  = count_q + {1'b0, push_n} - {2'd0, m_accept};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store up to two tokens per beat
  always_ff @(posedge clk_i) begin
    if (s_accept && res.r0_valid) begin
      q_mem[wr_ptr_q] <= res.r0;
    end
    if (s_accept && res.r1_valid) begin
      q_mem[wr_ptr_q + 2'd1] <= res.r1;
    end
  end

  assign head          = q_mem[rd_ptr_q];
  assign m_axis_tvalid = count_q != 3'd0;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {3'd0, head.overflow, head.bad_char, head.line_number,
                          head.text_length, head.text, head.int_value,
                          head.token_kind};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("token queue over capacity");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.r1_valid |-> res.r0_valid)
    else $error("second token without a first");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser) |->
      (res.r1_valid ? (res.r1.token_kind == stok_pkg::K_EOF && res.r1.last)
                    : (res.r0.token_kind == stok_pkg::K_EOF && res.r0.last)))
    else $error("end of input did not close with an eof token");

  a_eof_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser) |=> count_q != 3'd0)
    else $error("eof beat missing from queue");

endmodule

@@ design/stok_scan.sv @@
// Scanner core: mode and lexeme registers plus the per-byte next-state and
// token logic. Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           char_code_i,
  input  logic                 end_of_input_i,
  output stok_pkg::scan_res_t  res_o
);

  logic [3:0]  mode_q, mode_d;
  logic [63:0] text_q, text_d;
  logic [7:0]  len_q, len_d;
  logic [30:0] num_q, num_d;
  logic        sat_q, sat_d;
  logic [23:0] line_q, line_d;

  logic [7:0]  c;
  logic        is_alpha, is_digit;

  // Current lexeme with c appended
  logic [63:0] app_text;
  logic [7:0]  app_len;
  logic        app_sat;

  // Next decimal value
  logic [34:0] num_x;
  logic [30:0] num_next;
  logic        num_ovf;

  // Token held by the current mode
  logic          flush_emit;
  stok_pkg::tok_t flush_tok;

  // Byte handled from idle
  logic [3:0]     st_mode;
  logic [63:0]    st_text;
  logic [7:0]     st_len;
  logic [30:0]    st_num;
  logic           st_emit;
  logic           st_nl;
  stok_pkg::tok_t st_tok;

  logic [7:0]     pair_first;
  logic [4:0]     pair_kind;
  logic           pair_hit;
  logic           do_start;
  logic           do_flush;

  assign c        = char_code_i;
  assign is_alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  assign is_digit = c inside {[8'h30:8'h39]};

  always_comb begin
    app_text = text_q;
    for (int b = 0; b < 8; b++) begin
      if (len_q == 8'(b)) begin
        app_text[8*b +: 8] = c;
      end
    end
    app_len = (len_q < stok_pkg::STRING_MAX) ? len_q + 8'd1 : len_q;
    app_sat = sat_q | (len_q >= stok_pkg::STRING_MAX);
  end

  // value * 10 + digit as two shifted adds
  always_comb begin
    num_x    = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0}
             + {31'd0, 4'(c - stok_pkg::CH_ZERO)};
    num_ovf  = num_x > {4'd0, stok_pkg::INT_SAT};
    num_next = num_ovf ? stok_pkg::INT_SAT : num_x[30:0];
  end

  always_comb begin
    flush_emit = 1'b1;
    flush_tok  = '0;
    flush_tok.line_number = line_q;
    flush_tok.text_length = 8'd1;
    case (mode_q)
      stok_pkg::M_IDENT: begin
        flush_tok.token_kind  = stok_pkg::ident_kind(text_q, len_q);
        flush_tok.text        = text_q;
        flush_tok.text_length = len_q;
      end
      stok_pkg::M_NUM: begin
        flush_tok.token_kind  = stok_pkg::K_INT;
        flush_tok.int_value   = num_q;
        flush_tok.text        = text_q;
        flush_tok.text_length = len_q;
        flush_tok.overflow    = sat_q;
      end
      stok_pkg::M_STR: begin
        // only reached at end of input: unterminated
        flush_tok.token_kind  = stok_pkg::K_STR;
        flush_tok.text        = text_q;
        flush_tok.text_length = len_q;
        flush_tok.overflow    = 1'b1;
      end
      stok_pkg::M_EQ: begin
        flush_tok.token_kind = stok_pkg::K_ASSIGN;
        flush_tok.text       = {56'd0, stok_pkg::CH_EQ};
      end
      stok_pkg::M_LT: begin
        flush_tok.token_kind = stok_pkg::K_LT;
        flush_tok.text       = {56'd0, stok_pkg::CH_LT};
      end
      stok_pkg::M_GT: begin
        flush_tok.token_kind = stok_pkg::K_GT;
        flush_tok.text       = {56'd0, stok_pkg::CH_GT};
      end
      stok_pkg::M_PLUS: begin
        flush_tok.token_kind = stok_pkg::K_PLUS;
        flush_tok.text       = {56'd0, stok_pkg::CH_PLUS};
      end
      stok_pkg::M_MINUS: begin
        flush_tok.token_kind = stok_pkg::K_MINUS;
        flush_tok.text       = {56'd0, stok_pkg::CH_MINUS};
      end
      default: begin
        flush_emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_mode = stok_pkg::M_IDLE;
    st_text = '0;
    st_len  = '0;
    st_num  = '0;
    st_emit = 1'b0;
    st_nl   = 1'b0;
    st_tok  = '0;
    st_tok.line_number = line_q;
    st_tok.text        = {56'd0, c};
    st_tok.text_length = 8'd1;
    case (c)
      stok_pkg::CH_NL:     st_nl = 1'b1;
      stok_pkg::CH_SPACE,
      stok_pkg::CH_TAB:    st_nl = 1'b0;
      stok_pkg::CH_QUOTE: begin
        st_mode = stok_pkg::M_STR;
        st_text = {56'd0, c};
        st_len  = 8'd1;
      end
      stok_pkg::CH_EQ:     st_mode = stok_pkg::M_EQ;
      stok_pkg::CH_LT:     st_mode = stok_pkg::M_LT;
      stok_pkg::CH_GT:     st_mode = stok_pkg::M_GT;
      stok_pkg::CH_PLUS:   st_mode = stok_pkg::M_PLUS;
      stok_pkg::CH_MINUS:  st_mode = stok_pkg::M_MINUS;
      stok_pkg::CH_SEMI: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_SEMI;
      end
      stok_pkg::CH_LPAREN: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_LPAREN;
      end
      stok_pkg::CH_RPAREN: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_RPAREN;
      end
      stok_pkg::CH_LBRACE: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_LBRACE;
      end
      stok_pkg::CH_RBRACE: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_RBRACE;
      end
      stok_pkg::CH_COMMA: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_COMMA;
      end
      stok_pkg::CH_STAR: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_STAR;
      end
      stok_pkg::CH_SLASH: begin
        st_emit = 1'b1;
        st_tok.token_kind = stok_pkg::K_SLASH;
      end
      default: begin
        if (is_alpha) begin
          st_mode = stok_pkg::M_IDENT;
          st_text = {56'd0, c};
          st_len  = 8'd1;
        end else if (is_digit) begin
          st_mode = stok_pkg::M_NUM;
          st_text = {56'd0, c};
          st_len  = 8'd1;
          st_num  = {27'd0, 4'(c - stok_pkg::CH_ZERO)};
        end else begin
          st_emit = 1'b1;
          st_tok.token_kind = stok_pkg::K_ERROR;
          st_tok.bad_char   = c;
        end
      end
    endcase
  end

  always_comb begin
    pair_first = stok_pkg::CH_EQ;
    pair_kind  = stok_pkg::K_EQEQ;
    pair_hit   = 1'b0;
    case (mode_q)
      stok_pkg::M_EQ: begin
        pair_hit = (c == stok_pkg::CH_EQ);
      end
      stok_pkg::M_LT: begin
        pair_first = stok_pkg::CH_LT;
        pair_kind  = stok_pkg::K_LE;
        pair_hit   = (c == stok_pkg::CH_EQ);
      end
      stok_pkg::M_GT: begin
        pair_first = stok_pkg::CH_GT;
        pair_kind  = stok_pkg::K_GE;
        pair_hit   = (c == stok_pkg::CH_EQ);
      end
      stok_pkg::M_PLUS: begin
        pair_first = stok_pkg::CH_PLUS;
        pair_kind  = stok_pkg::K_PLUSPLUS;
        pair_hit   = (c == stok_pkg::CH_PLUS);
      end
      stok_pkg::M_MINUS: begin
        pair_first = stok_pkg::CH_MINUS;
        pair_kind  = stok_pkg::K_MINMIN;
        pair_hit   = (c == stok_pkg::CH_MINUS);
      end
      default: pair_hit = 1'b0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    text_d   = text_q;
    len_d    = len_q;
    num_d    = num_q;
    sat_d    = sat_q;
    line_d   = line_q;
    res_o    = '0;
    do_start = 1'b0;
    do_flush = 1'b0;

    if (end_of_input_i) begin
      res_o.r0_valid = 1'b1;
      if (flush_emit) begin
        res_o.r0       = flush_tok;
        res_o.r1_valid = 1'b1;
        res_o.r1.token_kind  = stok_pkg::K_EOF;
        res_o.r1.line_number = line_q;
        res_o.r1.last        = 1'b1;
      end else begin
        res_o.r0.token_kind  = stok_pkg::K_EOF;
        res_o.r0.line_number = line_q;
        res_o.r0.last        = 1'b1;
      end
      mode_d = stok_pkg::M_IDLE;
      text_d = '0;
      len_d  = '0;
      num_d  = '0;
      sat_d  = 1'b0;
    end else begin
      case (mode_q)
        stok_pkg::M_IDLE: do_start = 1'b1;
        stok_pkg::M_IDENT: begin
          if ((is_alpha || is_digit) && len_q < stok_pkg::IDENT_MAX - 8'd1) begin
            text_d = app_text;
            len_d  = app_len;
            sat_d  = app_sat;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        stok_pkg::M_NUM: begin
          if (is_digit) begin
            text_d = app_text;
            len_d  = app_len;
            num_d  = num_next;
            sat_d  = app_sat | num_ovf;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        stok_pkg::M_STR: begin
          text_d = app_text;
          len_d  = app_len;
          sat_d  = app_sat;
          if (c == stok_pkg::CH_QUOTE) begin
            mode_d = stok_pkg::M_IDLE;
            res_o.r0_valid = 1'b1;
            res_o.r0.token_kind  = stok_pkg::K_STR;
            res_o.r0.text        = app_text;
            res_o.r0.text_length = app_len;
            res_o.r0.line_number = line_q;
            res_o.r0.overflow    = app_sat;
            res_o.r0.last        = 1'b1;
          end
        end
        stok_pkg::M_EQ, stok_pkg::M_LT, stok_pkg::M_GT,
        stok_pkg::M_PLUS, stok_pkg::M_MINUS: begin
          if (pair_hit) begin
            mode_d = stok_pkg::M_IDLE;
            res_o.r0_valid = 1'b1;
            res_o.r0.token_kind  = pair_kind;
            res_o.r0.text        = {48'd0, c, pair_first};
            res_o.r0.text_length = 8'd2;
            res_o.r0.line_number = line_q;
            res_o.r0.last        = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_d = st_mode;
        text_d = st_text;
        len_d  = st_len;
        num_d  = st_num;
        sat_d  = 1'b0;
        if (st_nl && line_q != stok_pkg::LINE_SAT) begin
          line_d = line_q + 24'd1;
        end
        if (do_flush) begin
          res_o.r0_valid = 1'b1;
          res_o.r0       = flush_tok;
          res_o.r0.last  = !st_emit;
          res_o.r1_valid = st_emit;
          res_o.r1       = st_tok;
          res_o.r1.last  = 1'b1;
        end else begin
          res_o.r0_valid = st_emit;
          res_o.r0       = st_tok;
          res_o.r0.last  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stok_pkg::M_IDLE;
      text_q <= '0;
      len_q  <= '0;
      num_q  <= '0;
      sat_q  <= 1'b0;
      line_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      text_q <= text_d;
      len_q  <= len_d;
      num_q  <= num_d;
      sat_q  <= sat_d;
      line_q <= line_d;
    end
  end

endmodule
